[src/fpn_pkg.sv]
// Shared types, constants and helper functions for the fractal Perlin noise block.
package fpn_pkg;

    localparam logic [45:0] AMP_ONE = 46'h0000_4000_0000;
    localparam logic [45:0] AMP_CAP = 46'h2000_0000_0000;

    localparam logic [4:0] SETUP_LAST = 5'd6;
    localparam logic [4:0] OCT_LAST   = 5'd22;

    typedef enum logic [2:0] {
        CFG_OCTAVE_COUNT,
        CFG_PERSISTENCE,
        CFG_SCALE,
        CFG_OFFSET_X,
        CFG_OFFSET_Y,
        CFG_OFFSET_Z
    } t_cfg_idx;

    typedef struct packed {
        logic        [15:0] persistence;
        logic        [31:0] scale;
        logic signed [31:0] offset_x;
        logic signed [31:0] offset_y;
        logic signed [31:0] offset_z;
    } t_cfg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SETUP,
        ST_OCTAVE,
        ST_FINISH
    } t_state;

    typedef enum logic [4:0] {
        M_NONE, M_XLO, M_XHI, M_YLO, M_YHI, M_ZLO, M_ZHI,
        M_TXX, M_TYY, M_TZZ, M_TX3, M_TY3, M_TZ3, M_FU, M_FV, M_FW,
        M_L0, M_L1, M_L2, M_L3, M_LY0, M_LY1, M_LZ,
        M_NLO, M_NHI, M_ALO, M_AHI
    } t_mul;

    typedef enum logic [4:0] {
        W_NONE, W_PX_SET, W_PX_ADD, W_PY_SET, W_PY_ADD, W_PZ_SET, W_PZ_ADD,
        W_TXX, W_TYY, W_TZZ, W_TX3, W_TY3, W_TZ3, W_FU, W_FV, W_FW,
        W_L0, W_L1, W_L2, W_L3, W_LY0, W_LY1, W_LZ,
        W_TLO, W_TERM, W_ALO, W_AMP
    } t_wb;

    typedef enum logic [2:0] {
        HS_NONE,
        HS_ROW,
        HS_PLANE,
        HS_CORNER,
        HS_GRAD
    } t_hash;

    typedef struct packed {
        logic  load;
        t_mul  mul;
        t_wb   wb;
        t_hash hash;
        logic  finish;
    } t_cmd;

    localparam logic [7:0] PERM_TABLE [256] = '{
        8'd131, 8'd13, 8'd201, 8'd95, 8'd96, 8'd53, 8'd194, 8'd233, 8'd7, 8'd225, 8'd140,
        8'd36, 8'd103, 8'd30, 8'd69, 8'd142, 8'd8, 8'd99, 8'd37, 8'd240, 8'd21, 8'd10,
        8'd23, 8'd160, 8'd190, 8'd6, 8'd148, 8'd247, 8'd120, 8'd234, 8'd75, 8'd0, 8'd26,
        8'd197, 8'd62, 8'd94, 8'd252, 8'd219, 8'd203, 8'd117, 8'd35, 8'd11, 8'd32, 8'd57,
        8'd177, 8'd33, 8'd137, 8'd88, 8'd237, 8'd149, 8'd56, 8'd87, 8'd174, 8'd20, 8'd125,
        8'd136, 8'd171, 8'd168, 8'd68, 8'd175, 8'd74, 8'd165, 8'd71, 8'd134, 8'd139, 8'd48,
        8'd27, 8'd166, 8'd91, 8'd77, 8'd146, 8'd158, 8'd231, 8'd83, 8'd111, 8'd229, 8'd122,
        8'd60, 8'd211, 8'd133, 8'd230, 8'd220, 8'd105, 8'd92, 8'd41, 8'd55, 8'd46, 8'd245,
        8'd40, 8'd244, 8'd90, 8'd102, 8'd143, 8'd54, 8'd65, 8'd25, 8'd63, 8'd161, 8'd1,
        8'd216, 8'd80, 8'd73, 8'd209, 8'd76, 8'd132, 8'd187, 8'd208, 8'd89, 8'd18, 8'd169,
        8'd200, 8'd196, 8'd15, 8'd135, 8'd130, 8'd116, 8'd188, 8'd159, 8'd86, 8'd164,
        8'd100, 8'd109, 8'd198, 8'd173, 8'd186, 8'd3, 8'd64, 8'd52, 8'd217, 8'd226, 8'd250,
        8'd124, 8'd123, 8'd151, 8'd5, 8'd202, 8'd38, 8'd147, 8'd118, 8'd126, 8'd255, 8'd82,
        8'd85, 8'd212, 8'd207, 8'd206, 8'd59, 8'd227, 8'd47, 8'd16, 8'd58, 8'd17, 8'd182,
        8'd189, 8'd28, 8'd42, 8'd223, 8'd183, 8'd170, 8'd213, 8'd119, 8'd248, 8'd152, 8'd2,
        8'd44, 8'd154, 8'd163, 8'd70, 8'd221, 8'd153, 8'd101, 8'd155, 8'd167, 8'd43, 8'd172,
        8'd9, 8'd129, 8'd22, 8'd39, 8'd253, 8'd19, 8'd98, 8'd108, 8'd110, 8'd79, 8'd113,
        8'd224, 8'd232, 8'd178, 8'd185, 8'd112, 8'd104, 8'd218, 8'd246, 8'd97, 8'd228,
        8'd251, 8'd34, 8'd242, 8'd193, 8'd238, 8'd210, 8'd144, 8'd12, 8'd191, 8'd179,
        8'd162, 8'd241, 8'd81, 8'd51, 8'd145, 8'd235, 8'd249, 8'd14, 8'd239, 8'd107, 8'd49,
        8'd192, 8'd214, 8'd31, 8'd181, 8'd199, 8'd106, 8'd157, 8'd184, 8'd84, 8'd204,
        8'd176, 8'd115, 8'd121, 8'd50, 8'd45, 8'd127, 8'd4, 8'd150, 8'd254, 8'd138, 8'd236,
        8'd205, 8'd93, 8'd222, 8'd114, 8'd67, 8'd29, 8'd24, 8'd72, 8'd243, 8'd141, 8'd128,
        8'd195, 8'd78, 8'd66, 8'd215, 8'd61, 8'd156, 8'd180
    };

    // The 512-entry permutation is the 256-entry one repeated, so index mod 256.
    function automatic logic [7:0] f_perm(input logic [7:0] idx);
        return PERM_TABLE[idx];
    endfunction

    function automatic logic signed [19:0] f_grad(input logic [3:0] h,
                                                  input logic signed [17:0] x,
                                                  input logic signed [17:0] y,
                                                  input logic signed [17:0] z);
        logic signed [17:0] u;
        logic signed [17:0] v;
        logic signed [19:0] su;
        logic signed [19:0] sv;
        u  = (h < 4'd8) ? x : y;
        v  = (h < 4'd4) ? y : ((h == 4'd12 || h == 4'd14) ? x : z);
        su = {{2{u[17]}}, u};
        sv = {{2{v[17]}}, v};
        if (h[0]) su = -su;
        if (h[1]) sv = -sv;
        return su + sv;
    endfunction

    // floor(s / 2^16) of the fade polynomial 6t^2 - 15t*2^16 + 10*2^32, never negative
    function automatic logic [19:0] f_s16(input logic [15:0] t, input logic [31:0] t2);
        logic signed [37:0] s;
        s = 38'sd6 * $signed({6'b0, t2})
            - ($signed({6'b0, 16'b0, t}) * 38'sd15 <<< 16)
            + (38'sd10 <<< 32);
        return s[35:16];
    endfunction

endpackage

[src/fractal_perlin_noise_top.sv]
// Top level of the fractal Perlin noise block: configuration registers, sequencer and datapath.
// One point is taken when start is high and busy is low; its result appears on o_noise_value
// with o_noise_valid high for exactly one cycle. The octave count is clamped to 1..MAX_OCTAVES.
// A setup phase forms the scaled point on the shared 34x24 multiplier, then each octave runs on
// that same multiplier (fade curves, seven blends, octave weighting and amplitude update), and
// a finish state saturates the sum. Busy drops in the cycle the strobe is high, so a new
// point is taken only once the previous one is done. The result cannot be held off:
// capture it on the strobe. Configuration writes are always ready; write them only while
// busy is low.
module fractal_perlin_noise_top #(
    parameter int MAX_OCTAVES = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               i_kind,
    input  logic signed [31:0] i_coord_x,
    input  logic signed [31:0] i_coord_y,
    input  logic signed [31:0] i_coord_z,
    output logic               o_noise_valid,
    output logic signed [31:0] o_noise_value,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data
);
    import fpn_pkg::*;

    logic [4:0] r_octave_count;
    t_cfg       r_cfg;
    t_cmd       cmd;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_octave_count    <= 5'd4;
            r_cfg.persistence <= 16'd16384;
            r_cfg.scale       <= 32'd65536;
            r_cfg.offset_x    <= '0;
            r_cfg.offset_y    <= '0;
            r_cfg.offset_z    <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_OCTAVE_COUNT: r_octave_count    <= i_cfg_data[4:0];
                CFG_PERSISTENCE:  r_cfg.persistence <= i_cfg_data[15:0];
                CFG_SCALE:        r_cfg.scale       <= i_cfg_data;
                CFG_OFFSET_X:     r_cfg.offset_x    <= i_cfg_data;
                CFG_OFFSET_Y:     r_cfg.offset_y    <= i_cfg_data;
                CFG_OFFSET_Z:     r_cfg.offset_z    <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    fpn_ctrl #(
        .MAX_OCTAVES(MAX_OCTAVES)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .i_octave_count(r_octave_count),
        .o_busy        (busy),
        .o_cmd         (cmd)
    );

    fpn_datapath u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_cfg        (r_cfg),
        .i_kind       (i_kind),
        .i_coord_x    (i_coord_x),
        .i_coord_y    (i_coord_y),
        .i_coord_z    (i_coord_z),
        .o_noise_valid(o_noise_valid),
        .o_noise_value(o_noise_value)
    );

endmodule

[src/fpn_ctrl.sv]
// Sequencer for the noise datapath: setup, per-octave schedule and finish.
module fpn_ctrl #(
    parameter int MAX_OCTAVES = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [4:0]        i_octave_count,
    output logic              o_busy,
    output fpn_pkg::t_cmd     o_cmd
);
    import fpn_pkg::*;

    localparam int OCT_W = (MAX_OCTAVES > 1) ? $clog2(MAX_OCTAVES) : 1;

    t_state           r_state, n_state;
    logic [4:0]       r_step, n_step;
    logic [OCT_W-1:0] r_oct, n_oct;
    logic [5:0]       last_wide;
    logic [OCT_W-1:0] oct_last;

    always_comb begin
        if (i_octave_count == 5'd0) begin
            last_wide = 6'd0;
        end else if ({1'b0, i_octave_count} > 6'(MAX_OCTAVES)) begin
            last_wide = 6'(MAX_OCTAVES - 1);
        end else begin
            last_wide = {1'b0, i_octave_count} - 6'd1;
        end
        oct_last = last_wide[OCT_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= '0;
            r_oct   <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_oct   <= n_oct;
        end
    end

    always_comb begin
        n_state = r_state;
        n_step  = r_step + 5'd1;
        n_oct   = r_oct;
        o_cmd   = '{load: 1'b0, mul: M_NONE, wb: W_NONE, hash: HS_NONE, finish: 1'b0};
        case (r_state)
            ST_IDLE: begin
                n_step = '0;
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_SETUP;
                end
            end
            ST_SETUP: begin
                case (r_step)
                    5'd0: o_cmd.mul = M_XLO;
                    5'd1: begin o_cmd.mul = M_XHI; o_cmd.wb = W_PX_SET; end
                    5'd2: begin o_cmd.mul = M_YLO; o_cmd.wb = W_PX_ADD; end
                    5'd3: begin o_cmd.mul = M_YHI; o_cmd.wb = W_PY_SET; end
                    5'd4: begin o_cmd.mul = M_ZLO; o_cmd.wb = W_PY_ADD; end
                    5'd5: begin o_cmd.mul = M_ZHI; o_cmd.wb = W_PZ_SET; end
                    default: o_cmd.wb = W_PZ_ADD;
                endcase
                if (r_step == SETUP_LAST) begin
                    n_state = ST_OCTAVE;
                    n_step  = '0;
                    n_oct   = '0;
                end
            end
            ST_OCTAVE: begin
                case (r_step)
                    5'd0:  begin o_cmd.mul = M_TXX; o_cmd.hash = HS_ROW; end
                    5'd1:  begin o_cmd.mul = M_TYY; o_cmd.wb = W_TXX; o_cmd.hash = HS_PLANE; end
                    5'd2:  begin o_cmd.mul = M_TZZ; o_cmd.wb = W_TYY; o_cmd.hash = HS_CORNER; end
                    5'd3:  begin o_cmd.mul = M_TX3; o_cmd.wb = W_TZZ; o_cmd.hash = HS_GRAD; end
                    5'd4:  begin o_cmd.mul = M_TY3; o_cmd.wb = W_TX3; end
                    5'd5:  begin o_cmd.mul = M_TZ3; o_cmd.wb = W_TY3; end
                    5'd6:  begin o_cmd.mul = M_FU;  o_cmd.wb = W_TZ3; end
                    5'd7:  begin o_cmd.mul = M_FV;  o_cmd.wb = W_FU; end
                    5'd8:  begin o_cmd.mul = M_FW;  o_cmd.wb = W_FV; end
                    5'd9:  begin o_cmd.mul = M_L0;  o_cmd.wb = W_FW; end
                    5'd10: begin o_cmd.mul = M_L1;  o_cmd.wb = W_L0; end
                    5'd11: begin o_cmd.mul = M_L2;  o_cmd.wb = W_L1; end
                    5'd12: begin o_cmd.mul = M_L3;  o_cmd.wb = W_L2; end
                    5'd13: begin o_cmd.mul = M_LY0; o_cmd.wb = W_L3; end
                    5'd14: begin o_cmd.mul = M_LY1; o_cmd.wb = W_LY0; end
                    5'd15: o_cmd.wb = W_LY1;
                    5'd16: o_cmd.mul = M_LZ;
                    5'd17: o_cmd.wb = W_LZ;
                    5'd18: o_cmd.mul = M_NLO;
                    5'd19: begin o_cmd.mul = M_NHI; o_cmd.wb = W_TLO; end
                    5'd20: begin o_cmd.mul = M_ALO; o_cmd.wb = W_TERM; end
                    5'd21: begin o_cmd.mul = M_AHI; o_cmd.wb = W_ALO; end
                    default: o_cmd.wb = W_AMP;
                endcase
                if (r_step == OCT_LAST) begin
                    n_step = '0;
                    if (r_oct == oct_last) begin
                        n_state = ST_FINISH;
                    end else begin
                        n_oct = r_oct + 1'b1;
                    end
                end
            end
            ST_FINISH: begin
                o_cmd.finish = 1'b1;
                n_state      = ST_IDLE;
                n_step       = '0;
            end
            default: begin
                n_state = ST_IDLE;
                n_step  = '0;
            end
        endcase
    end

    assign o_busy = (r_state != ST_IDLE);

endmodule

[src/fpn_datapath.sv]
// Noise datapath: shared multiplier, hash tables, gradients, lerp and octave sum.
module fpn_datapath (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  fpn_pkg::t_cmd      i_cmd,
    input  fpn_pkg::t_cfg      i_cfg,
    input  logic               i_kind,
    input  logic signed [31:0] i_coord_x,
    input  logic signed [31:0] i_coord_y,
    input  logic signed [31:0] i_coord_z,
    output logic               o_noise_valid,
    output logic signed [31:0] o_noise_value
);
    import fpn_pkg::*;

    logic signed [32:0] r_sx, r_sy, r_sz;
    logic [39:0]        r_px, r_py, r_pz;
    logic [31:0]        r_txx, r_tyy, r_tzz;
    logic [15:0]        r_t3x, r_t3y, r_t3z;
    logic [16:0]        r_u, r_v, r_w;
    logic [7:0]         r_ha, r_hb, r_haa, r_hab, r_hba, r_hbb;
    logic [7:0]         r_hash [8];
    logic signed [19:0] r_g [8];
    logic signed [57:0] r_prod;
    logic signed [43:0] r_tlo;
    logic [38:0]        r_alo;
    logic [45:0]        r_amp;
    logic signed [39:0] r_total;
    logic signed [31:0] r_out;
    logic               r_strobe;

    logic signed [33:0] mul_a;
    logic signed [23:0] mul_b;
    logic signed [20:0] diff;
    logic [15:0]        tx, ty, tz;
    logic [7:0]         cx, cy, cz;
    logic signed [17:0] fx, fy, fz, gx, gy, gz;
    logic signed [19:0] lerp_step;
    logic signed [67:0] term_full;
    logic signed [39:0] term;
    logic [61:0]        amp_full;
    logic [46:0]        amp_next;

    assign tx = r_px[31:16];
    assign ty = r_py[31:16];
    assign tz = r_pz[31:16];
    assign cx = r_px[39:32];
    assign cy = r_py[39:32];
    assign cz = r_pz[39:32];
    assign fx = $signed({2'b0, tx});
    assign fy = $signed({2'b0, ty});
    assign fz = $signed({2'b0, tz});
    assign gx = fx - 18'sh10000;
    assign gy = fy - 18'sh10000;
    assign gz = fz - 18'sh10000;

    assign lerp_step = r_prod[35:16];
    assign term_full = {r_prod[43], r_prod[43:0], 23'b0} + {{24{r_tlo[43]}}, r_tlo};
    assign term      = {{2{term_full[67]}}, term_full[67:30]};
    assign amp_full  = {r_prod[38:0], 23'b0} + {23'b0, r_alo};
    assign amp_next  = amp_full[61:15];

    // operand select for the shared multiplier
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        diff  = '0;
        case (i_cmd.mul)
            M_XLO: begin mul_a = {r_sx[32], r_sx}; mul_b = {8'b0, i_cfg.scale[15:0]}; end
            M_XHI: begin mul_a = {r_sx[32], r_sx}; mul_b = {8'b0, i_cfg.scale[31:16]}; end
            M_YLO: begin mul_a = {r_sy[32], r_sy}; mul_b = {8'b0, i_cfg.scale[15:0]}; end
            M_YHI: begin mul_a = {r_sy[32], r_sy}; mul_b = {8'b0, i_cfg.scale[31:16]}; end
            M_ZLO: begin mul_a = {r_sz[32], r_sz}; mul_b = {8'b0, i_cfg.scale[15:0]}; end
            M_ZHI: begin mul_a = {r_sz[32], r_sz}; mul_b = {8'b0, i_cfg.scale[31:16]}; end
            M_TXX: begin mul_a = {18'b0, tx}; mul_b = {8'b0, tx}; end
            M_TYY: begin mul_a = {18'b0, ty}; mul_b = {8'b0, ty}; end
            M_TZZ: begin mul_a = {18'b0, tz}; mul_b = {8'b0, tz}; end
            M_TX3: begin mul_a = {2'b0, r_txx}; mul_b = {8'b0, tx}; end
            M_TY3: begin mul_a = {2'b0, r_tyy}; mul_b = {8'b0, ty}; end
            M_TZ3: begin mul_a = {2'b0, r_tzz}; mul_b = {8'b0, tz}; end
            M_FU: begin mul_a = {18'b0, r_t3x}; mul_b = {4'b0, f_s16(tx, r_txx)}; end
            M_FV: begin mul_a = {18'b0, r_t3y}; mul_b = {4'b0, f_s16(ty, r_tyy)}; end
            M_FW: begin mul_a = {18'b0, r_t3z}; mul_b = {4'b0, f_s16(tz, r_tzz)}; end
            M_L0: begin
                diff  = {r_g[1][19], r_g[1]} - {r_g[0][19], r_g[0]};
                mul_a = {{13{diff[20]}}, diff};
                mul_b = {7'b0, r_u};
            end
            M_L1: begin
                diff  = {r_g[3][19], r_g[3]} - {r_g[2][19], r_g[2]};
                mul_a = {{13{diff[20]}}, diff};
                mul_b = {7'b0, r_u};
            end
            M_L2: begin
                diff  = {r_g[5][19], r_g[5]} - {r_g[4][19], r_g[4]};
                mul_a = {{13{diff[20]}}, diff};
                mul_b = {7'b0, r_u};
            end
            M_L3: begin
                diff  = {r_g[7][19], r_g[7]} - {r_g[6][19], r_g[6]};
                mul_a = {{13{diff[20]}}, diff};
                mul_b = {7'b0, r_u};
            end
            M_LY0: begin
                diff  = {r_g[2][19], r_g[2]} - {r_g[0][19], r_g[0]};
                mul_a = {{13{diff[20]}}, diff};
                mul_b = {7'b0, r_v};
            end
            M_LY1: begin
                diff  = {r_g[6][19], r_g[6]} - {r_g[4][19], r_g[4]};
                mul_a = {{13{diff[20]}}, diff};
                mul_b = {7'b0, r_v};
            end
            M_LZ: begin
                diff  = {r_g[4][19], r_g[4]} - {r_g[0][19], r_g[0]};
                mul_a = {{13{diff[20]}}, diff};
                mul_b = {7'b0, r_w};
            end
            M_NLO: begin mul_a = {{14{r_g[0][19]}}, r_g[0]}; mul_b = {1'b0, r_amp[22:0]}; end
            M_NHI: begin mul_a = {{14{r_g[0][19]}}, r_g[0]}; mul_b = {1'b0, r_amp[45:23]}; end
            M_ALO: begin mul_a = {11'b0, r_amp[22:0]}; mul_b = {8'b0, i_cfg.persistence}; end
            M_AHI: begin mul_a = {11'b0, r_amp[45:23]}; mul_b = {8'b0, i_cfg.persistence}; end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;

        if (i_cmd.load) begin
            r_sx    <= {i_coord_x[31], i_coord_x} + {i_cfg.offset_x[31], i_cfg.offset_x};
            r_sy    <= {i_coord_y[31], i_coord_y} + {i_cfg.offset_y[31], i_cfg.offset_y};
            r_sz    <= i_kind ? ({i_coord_z[31], i_coord_z} + {i_cfg.offset_z[31], i_cfg.offset_z})
                              : 33'sd0;
            r_amp   <= AMP_ONE;
            r_total <= '0;
        end

        case (i_cmd.hash)
            HS_ROW: begin
                r_ha <= f_perm(cx) + cy;
                r_hb <= f_perm(cx + 8'd1) + cy;
            end
            HS_PLANE: begin
                r_haa <= f_perm(r_ha) + cz;
                r_hab <= f_perm(r_ha + 8'd1) + cz;
                r_hba <= f_perm(r_hb) + cz;
                r_hbb <= f_perm(r_hb + 8'd1) + cz;
            end
            HS_CORNER: begin
                r_hash[0] <= f_perm(r_haa);
                r_hash[1] <= f_perm(r_hba);
                r_hash[2] <= f_perm(r_hab);
                r_hash[3] <= f_perm(r_hbb);
                r_hash[4] <= f_perm(r_haa + 8'd1);
                r_hash[5] <= f_perm(r_hba + 8'd1);
                r_hash[6] <= f_perm(r_hab + 8'd1);
                r_hash[7] <= f_perm(r_hbb + 8'd1);
            end
            HS_GRAD: begin
                r_g[0] <= f_grad(r_hash[0][3:0], fx, fy, fz);
                r_g[1] <= f_grad(r_hash[1][3:0], gx, fy, fz);
                r_g[2] <= f_grad(r_hash[2][3:0], fx, gy, fz);
                r_g[3] <= f_grad(r_hash[3][3:0], gx, gy, fz);
                r_g[4] <= f_grad(r_hash[4][3:0], fx, fy, gz);
                r_g[5] <= f_grad(r_hash[5][3:0], gx, fy, gz);
                r_g[6] <= f_grad(r_hash[6][3:0], fx, gy, gz);
                r_g[7] <= f_grad(r_hash[7][3:0], gx, gy, gz);
            end
            default: begin
            end
        endcase

        case (i_cmd.wb)
            W_PX_SET: r_px <= r_prod[39:0];
            W_PX_ADD: r_px <= r_px + {r_prod[23:0], 16'b0};
            W_PY_SET: r_py <= r_prod[39:0];
            W_PY_ADD: r_py <= r_py + {r_prod[23:0], 16'b0};
            W_PZ_SET: r_pz <= r_prod[39:0];
            W_PZ_ADD: r_pz <= r_pz + {r_prod[23:0], 16'b0};
            W_TXX:    r_txx <= r_prod[31:0];
            W_TYY:    r_tyy <= r_prod[31:0];
            W_TZZ:    r_tzz <= r_prod[31:0];
            W_TX3:    r_t3x <= r_prod[47:32];
            W_TY3:    r_t3y <= r_prod[47:32];
            W_TZ3:    r_t3z <= r_prod[47:32];
            W_FU:     r_u <= r_prod[32:16];
            W_FV:     r_v <= r_prod[32:16];
            W_FW:     r_w <= r_prod[32:16];
            W_L0:     r_g[0] <= r_g[0] + lerp_step;
            W_L1:     r_g[2] <= r_g[2] + lerp_step;
            W_L2:     r_g[4] <= r_g[4] + lerp_step;
            W_L3:     r_g[6] <= r_g[6] + lerp_step;
            W_LY0:    r_g[0] <= r_g[0] + lerp_step;
            W_LY1:    r_g[4] <= r_g[4] + lerp_step;
            W_LZ:     r_g[0] <= r_g[0] + lerp_step;
            W_TLO:    r_tlo <= r_prod[43:0];
            W_TERM:   r_total <= r_total + term;
            W_ALO:    r_alo <= r_prod[38:0];
            W_AMP: begin
                r_amp <= (amp_next > {1'b0, AMP_CAP}) ? AMP_CAP : amp_next[45:0];
                // advance to the next octave: double the scaled point
                r_px  <= {r_px[38:0], 1'b0};
                r_py  <= {r_py[38:0], 1'b0};
                r_pz  <= {r_pz[38:0], 1'b0};
            end
            default: begin
            end
        endcase

        if (i_cmd.finish) begin
            if (r_total > 40'sh007FFF_FFFF) begin
                r_out <= 32'sh7FFF_FFFF;
            end else if (r_total < -40'sh0080000000) begin
                r_out <= 32'sh8000_0000;
            end else begin
                r_out <= r_total[31:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_cmd.finish;
        end
    end

    assign o_noise_valid = r_strobe;
    assign o_noise_value = r_out;

endmodule

[test/fractal_perlin_noise_top_test.sv]
// Self-checking testbench for fractal_perlin_noise_top: predicts each noise value and compares.
module fractal_perlin_noise_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import fpn_pkg::*;

    localparam int         NUM_RANDOM   = 1050;
    localparam int         PHASE_ITEMS  = 75;
    localparam int         STALL_LIMIT  = 4000;
    localparam int         OCT_LIMIT    = 16;
    localparam logic [2:0] CFG_SPARE_IDX = 3'd6;
    localparam logic [2:0] CFG_TOP_IDX   = 3'd7;

    class noise_scoreboard;
        logic [4:0]         octave_count;
        logic [15:0]        persistence;
        logic [31:0]        scale;
        logic signed [31:0] offset_x;
        logic signed [31:0] offset_y;
        logic signed [31:0] offset_z;
        logic signed [31:0] expected_noise[$];
        int                 mismatches;
        int                 points_checked;
        int                 saturated_seen;

        function new();
            octave_count = 5'd4;
            persistence = 16'd16384;
            scale = 32'd65536;
            offset_x = '0;
            offset_y = '0;
            offset_z = '0;
            mismatches = 0;
            points_checked = 0;
            saturated_seen = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [31:0] d);
            case (t_cfg_idx'(idx))
                CFG_OCTAVE_COUNT: octave_count = d[4:0];
                CFG_PERSISTENCE:  persistence = d[15:0];
                CFG_SCALE:        scale = d;
                CFG_OFFSET_X:     offset_x = d;
                CFG_OFFSET_Y:     offset_y = d;
                CFG_OFFSET_Z:     offset_z = d;
                default: ;
            endcase
        endfunction

        function longint perm_at(longint i);
            return longint'(PERM_TABLE[i & 255]);
        endfunction

        function longint fade(longint t);
            longint s;
            longint t3;
            s = 6 * t * t - 15 * t * 65536 + 10 * 64'sd4294967296;
            t3 = (t * t * t) >>> 32;
            return (t3 * (s >>> 16)) >>> 16;
        endfunction

        function longint mix(longint t, longint a, longint b);
            return a + ((t * (b - a)) >>> 16);
        endfunction

        function longint grad(longint hash, longint x, longint y, longint z);
            int     h;
            longint u;
            longint v;
            h = int'(hash & 15);
            u = (h < 8) ? x : y;
            v = (h < 4) ? y : ((h == 12 || h == 14) ? x : z);
            return ((h & 1) ? -u : u) + ((h & 2) ? -v : v);
        endfunction

        function longint octave_noise(longint cx, longint cy, longint cz,
                                      longint fx, longint fy, longint fz);
            longint u, v, w, gx, gy, gz, a, aa, ab, b, ba, bb, near_z, far_z;
            u = fade(fx);
            v = fade(fy);
            w = fade(fz);
            gx = fx - 65536;
            gy = fy - 65536;
            gz = fz - 65536;
            a = perm_at(cx) + cy;
            aa = perm_at(a) + cz;
            ab = perm_at(a + 1) + cz;
            b = perm_at(cx + 1) + cy;
            ba = perm_at(b) + cz;
            bb = perm_at(b + 1) + cz;
            near_z = mix(v,
                mix(u, grad(perm_at(aa), fx, fy, fz), grad(perm_at(ba), gx, fy, fz)),
                mix(u, grad(perm_at(ab), fx, gy, fz), grad(perm_at(bb), gx, gy, fz)));
            far_z = mix(v,
                mix(u, grad(perm_at(aa + 1), fx, fy, gz), grad(perm_at(ba + 1), gx, fy, gz)),
                mix(u, grad(perm_at(ab + 1), fx, gy, gz), grad(perm_at(bb + 1), gx, gy, gz)));
            return mix(w, near_z, far_z);
        endfunction

        function void note_point(logic kind, logic signed [31:0] x, logic signed [31:0] y,
                                 logic signed [31:0] z);
            logic [63:0] px, py, pz, qx, qy, qz;
            longint      amp;
            longint      total;
            longint      noise;
            int          n;
            px = 64'(longint'(x) + longint'(offset_x)) * {32'b0, scale};
            py = 64'(longint'(y) + longint'(offset_y)) * {32'b0, scale};
            pz = kind ? 64'(longint'(z) + longint'(offset_z)) * {32'b0, scale} : 64'd0;
            n = int'(octave_count);
            if (n < 1) n = 1;
            if (n > OCT_LIMIT) n = OCT_LIMIT;
            amp = 64'sd1 << 30;
            total = 0;
            for (int i = 0; i < n; i++) begin
                qx = px << i;
                qy = py << i;
                qz = pz << i;
                noise = octave_noise(qx[39:32], qy[39:32], qz[39:32],
                                     qx[31:16], qy[31:16], qz[31:16]);
                total += (noise * amp) >>> 30;
                amp = (amp * longint'(persistence)) >>> 15;
                if (amp > (64'sd1 << 45)) amp = 64'sd1 << 45;
            end
            if (total > 64'sd2147483647) begin
                total = 64'sd2147483647;
                saturated_seen++;
            end else if (total < -64'sd2147483648) begin
                total = -64'sd2147483648;
                saturated_seen++;
            end
            expected_noise.push_back(total[31:0]);
        endfunction

        task report(string what);
            $display("MISMATCH @%0t: %s", $realtime, what);
            mismatches++;
        endtask

        task check_noise(logic signed [31:0] got);
            logic signed [31:0] want;
            if (expected_noise.size() == 0) begin
                report($sformatf("noise_value %0d with nothing pending", got));
            end else begin
                want = expected_noise.pop_front();
                points_checked++;
                if (got !== want)
                    report($sformatf("noise_value got %0d expected %0d", got, want));
            end
        endtask
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic               i_kind;
    logic signed [31:0] i_coord_x;
    logic signed [31:0] i_coord_y;
    logic signed [31:0] i_coord_z;
    logic               o_noise_valid;
    logic signed [31:0] o_noise_value;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [2:0]         i_cfg_index;
    logic [31:0]        i_cfg_data;

    noise_scoreboard sb = new();
    int              stall_cycles;
    int              points_sent;
    bit              no_idle;

    fractal_perlin_noise_top dut (.*);

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_noise_valid) sb.check_noise(o_noise_value);
    end

    // Watchdog: any beat on either side restarts the count.
    always @(posedge i_clk) begin
        if ((start && !busy) || o_noise_valid || (i_cfg_valid && o_cfg_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("watchdog expired with %0d points pending", sb.expected_noise.size());
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    task automatic send_point(logic kind, logic signed [31:0] x, logic signed [31:0] y,
                              logic signed [31:0] z);
        int gap;
        if (!no_idle && $urandom_range(99) < 16) begin
            // hold start low, once the block is idle, for a random gap in which it could take a beat
            gap = $urandom_range(1, 4);
            start <= 1'b0;
            do @(posedge i_clk); while (busy);
            repeat (gap - 1) @(posedge i_clk);
        end
        start <= 1'b1;
        i_kind <= kind;
        i_coord_x <= x;
        i_coord_y <= y;
        i_coord_z <= z;
        do @(posedge i_clk); while (busy);
        sb.note_point(kind, x, y, z);
        points_sent++;
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (sb.expected_noise.size() != 0) @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] d);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= d;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_reg(idx, d);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic write_all(logic [4:0] oct, logic [15:0] pers, logic [31:0] scl,
                             logic [31:0] ox, logic [31:0] oy, logic [31:0] oz);
        drain();
        write_reg(CFG_OCTAVE_COUNT, {27'b0, oct});
        write_reg(CFG_PERSISTENCE, {16'b0, pers});
        write_reg(CFG_SCALE, scl);
        write_reg(CFG_OFFSET_X, ox);
        write_reg(CFG_OFFSET_Y, oy);
        write_reg(CFG_OFFSET_Z, oz);
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(3))
            0:       return $urandom;
            1:       return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return 32'($signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000);
        endcase
    endfunction

    task automatic config_phase(int p);
        logic [4:0]  oct;
        logic [15:0] pers;
        logic [31:0] scl;
        oct = 5'($urandom_range(0, 5));
        pers = $urandom_range(3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 32768));
        scl = 32'($urandom_range(32'h0000_1000, 32'h0004_0000));
        case (p)
            2: begin oct = 5'd16; pers = 16'hFFFF; end   // amplitude cap, sum saturates
            4: scl = 32'd0;
            6: begin oct = 5'd31; pers = 16'd0; end
            8: begin scl = 32'hFFFF_FFFF; pers = 16'd32768; end
            10: oct = 5'd1;
            default: ;
        endcase
        if (p % 3 == 1)
            write_all(oct, pers, scl, 32'h8000_0000, 32'h7FFF_FFFF, $urandom);
        else
            write_all(oct, pers, scl, rand_coord(), rand_coord(), rand_coord());
    endtask

    initial begin
        logic signed [31:0] edge_vals[6];
        edge_vals = '{32'sh0, 32'sh7FFF_FFFF, -32'sh8000_0000, 32'sh0001_8000,
                      -32'sh0000_4000, 32'sh00FF_FFFF};
        points_sent = 0;
        stall_cycles = 0;
        no_idle = 1'b0;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_kind = 1'b0;
        i_coord_x = '0;
        i_coord_y = '0;
        i_coord_z = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed points at reset settings: extremes, both kinds, z ignored in 2D.
        foreach (edge_vals[k]) begin
            send_point(1'b0, edge_vals[k], edge_vals[5 - k], -32'sh1);
            send_point(1'b1, edge_vals[k], edge_vals[(k + 2) % 6], edge_vals[5 - k]);
        end
        send_point(1'b0, 32'sh0002_3456, 32'sh0005_789A, 32'sh7FFF_FFFF);
        // Dropped register index must not disturb anything.
        drain();
        write_reg(CFG_SPARE_IDX, 32'hFFFF_FFFF);
        write_reg(CFG_TOP_IDX, 32'h0000_0000);
        send_point(1'b1, 32'sh0003_0000, 32'sh0004_8000, 32'sh0001_0001);
        write_all(5'd16, 16'hFFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        send_point(1'b1, 32'sh7FFF_FFFF, -32'sh8000_0000, 32'sh1234_5678);
        send_point(1'b0, 32'sh1234_5678, 32'sh0, 32'sh0);

        for (int i = 0; i < NUM_RANDOM; i++) begin
            if (i % PHASE_ITEMS == 0) config_phase(i / PHASE_ITEMS);
            no_idle = (i >= 300 && i < 500);
            if (i == 600) drain();
            send_point(1'($urandom), rand_coord(), rand_coord(), rand_coord());
        end
        drain();
        repeat (20) @(posedge i_clk);

        $display("covered %0d points over %0d register settings, %0d saturated sums",
                 points_sent, NUM_RANDOM / PHASE_ITEMS + 2, sb.saturated_seen);
        $display("checked %0d results, %0d mismatches", sb.points_checked, sb.mismatches);
        if (sb.mismatches == 0 && sb.expected_noise.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
